// ===== rtl/picture_buffer_output_bumping_defines.svh =====
// assertion macros for the picture buffer output bumping block
// no dependencies; taken in by the files that assert
`ifndef PICTURE_BUFFER_OUTPUT_BUMPING_DEFINES_SVH
`define PICTURE_BUFFER_OUTPUT_BUMPING_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PBOB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PBOB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pbob_pkg.sv =====
// shared types and constants of the picture buffer output bumping block
// no dependencies
`default_nettype none

package pbob_pkg;

	localparam int unsigned BUFFER_SLOTS_DEF = 16;
	localparam int unsigned MAX_RESULTS      = 16;
	localparam int unsigned RES_CNT_W        = $clog2(MAX_RESULTS + 1);

	// field widths
	localparam int unsigned OPCODE_W     = 3;
	localparam int unsigned SLOT_FIELD_W = 4;
	localparam int unsigned ORDER_W      = 32;
	localparam int unsigned SEQ_W        = 8;
	localparam int unsigned ENTRY_W      = SEQ_W + ORDER_W;
	// slot indexes that the slot_index field can name
	localparam int unsigned SLOT_INDEX_RANGE = 2 ** SLOT_FIELD_W;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_MARK   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_DRAIN  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_FLUSH  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_EVICT  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_DROP   = 3'd5;

	// configuration registers
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;
	localparam int unsigned REORDER_W  = 4;
	localparam int unsigned BUFSIZE_W  = 5;
	localparam logic [CFG_IDX_W-1:0] REG_REORDER_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BUFFER_SIZE = 1'd1;
	localparam logic [REORDER_W-1:0] REORDER_LIMIT_RST   = 4'd0;
	localparam logic [BUFSIZE_W-1:0] MAX_BUFFER_SIZE_RST = 5'd16;

	typedef struct packed {
		logic [OPCODE_W-1:0]       opcode;
		logic [SLOT_FIELD_W-1:0]   slot_index;
		logic signed [ORDER_W-1:0] pic_order;
		logic [SEQ_W-1:0]          sequence_id;
		logic                      wants_output;
		logic                      short_term_mark;
		logic                      long_term_mark;
	} in_t;

	typedef struct packed {
		logic                      emitted;
		logic [SLOT_FIELD_W-1:0]   result_slot;
		logic signed [ORDER_W-1:0] result_order;
		logic [SEQ_W-1:0]          result_sequence;
		logic                      status;
		logic                      last_result;
	} out_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_FULL,
		RES_INSERT,
		RES_BUMP
	} res_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      latch;
		logic      sweep;
		logic      evict;
		logic      mark;
		logic      drop;
		logic      scan_start;
		logic      ins_write;
		logic      bump;
		logic      res_load;
		res_kind_t res_kind;
		logic      res_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic                scan_done;
		logic                free_found;
		logic                go_now;
		logic                go_next;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/pbob_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pbob_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pbob_dp.sv =====
// datapath: slot flags, picture entry ram, slot scan and result register
// depends on pbob_pkg and pbob_ram
`default_nettype none

module pbob_dp #(
	parameter int unsigned BUFFER_SLOTS = pbob_pkg::BUFFER_SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pbob_pkg::in_t                   item,
	input  wire pbob_pkg::cmd_t                  cmd,
	input  wire logic                            cfg_we,
	input  wire logic [pbob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pbob_pkg::CFG_DATA_W-1:0] cfg_data,
	output      pbob_pkg::status_t               st,
	output      pbob_pkg::out_t                  result
);

	import pbob_pkg::*;

	localparam int unsigned SLOT_W = $clog2(BUFFER_SLOTS);
	localparam int unsigned CUR_W  = $clog2(BUFFER_SLOTS + 1);
	localparam int unsigned CNT_W  = CUR_W;
	localparam int unsigned CMP_W  = (CNT_W > BUFSIZE_W) ? CNT_W : BUFSIZE_W;
	localparam logic [CUR_W-1:0]  CUR_NONE  = CUR_W'(BUFFER_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BUFFER_SLOTS - 1);

	in_t                   item_q;
	logic [REORDER_W-1:0]  reorder_lim_q;
	logic [BUFSIZE_W-1:0]  max_buffer_size_q;

	logic [BUFFER_SLOTS-1:0] used_q, pend_q, sref_q, lref_q;
	logic [BUFFER_SLOTS-1:0] used_n, pend_n, sref_n, lref_n;
	logic [BUFFER_SLOTS-1:0] idle, clr, cur_mask, idx_mask, ff_mask, best_mask, mk;
	logic [CUR_W-1:0]        cur_q;

	// slot scan
	logic              scan_run_q;
	logic [SLOT_W-1:0] scan_idx_q;
	logic              valid_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [ENTRY_W-1:0] rd_data;

	logic [CNT_W-1:0]   used_cnt_q, pend_cnt_q;
	logic               best_valid_q;
	logic [SLOT_W-1:0]  best_slot_q;
	logic [ENTRY_W-1:0] best_data_q;
	logic               ff_valid_q;
	logic [SLOT_W-1:0]  ff_slot_q;

	logic               s1_used, s1_pend, better;
	logic [ENTRY_W-1:0] key_rd, key_best;

	logic [CMP_W-1:0] pend_ext, pend_dec, used_ext, mr_ext, mbs_ext;
	logic             flush_op, bump_cond_now, bump_cond_next;

	out_t res_q, res_n;

	// item and configuration
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reorder_lim_q     <= REORDER_LIMIT_RST;
			max_buffer_size_q <= MAX_BUFFER_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REORDER_LIMIT:   reorder_lim_q     <= cfg_data[REORDER_W-1:0];
				REG_MAX_BUFFER_SIZE: max_buffer_size_q <= cfg_data[BUFSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// per-slot masks and next flag state
	always_comb begin
		idle = used_q & ~sref_q & ~lref_q & ~pend_q;
		for (int i = 0; i < BUFFER_SLOTS; i++) begin
			cur_mask[i]  = (cur_q == CUR_W'(i));
			idx_mask[i]  = (i < SLOT_INDEX_RANGE) &&
				(item_q.slot_index == SLOT_FIELD_W'(i));
			ff_mask[i]   = (ff_slot_q == SLOT_W'(i));
			best_mask[i] = (best_slot_q == SLOT_W'(i));
		end

		clr = '0;
		if (cmd.sweep) begin
			clr = idle;
		end
		if (cmd.evict) begin
			clr = idle & ~cur_mask;
		end
		if (cmd.drop) begin
			clr = cur_mask;
		end

		used_n = used_q & ~clr;
		pend_n = pend_q & ~clr;
		sref_n = sref_q & ~clr;
		lref_n = lref_q & ~clr;

		mk = cmd.mark ? (idx_mask & used_q) : '0;
		sref_n = (sref_n & ~mk) | (mk & {BUFFER_SLOTS{item_q.short_term_mark}});
		lref_n = (lref_n & ~mk) | (mk & {BUFFER_SLOTS{item_q.long_term_mark}});

		if (cmd.ins_write) begin
			used_n = used_n | ff_mask;
			pend_n = (pend_n & ~ff_mask) | (ff_mask & {BUFFER_SLOTS{item_q.wants_output}});
			sref_n = sref_n & ~ff_mask;
			lref_n = lref_n & ~ff_mask;
		end
		if (cmd.bump) begin
			pend_n = pend_n & ~best_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			pend_q <= '0;
			sref_q <= '0;
			lref_q <= '0;
			cur_q  <= CUR_NONE;
		end else begin
			used_q <= used_n;
			pend_q <= pend_n;
			sref_q <= sref_n;
			lref_q <= lref_n;
			if (cmd.drop) begin
				cur_q <= CUR_NONE;
			end else if (cmd.ins_write) begin
				cur_q <= CUR_W'(ff_slot_q);
			end
		end
	end

	// entry store: sequence id above order count
	pbob_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(BUFFER_SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (cmd.ins_write),
		.waddr(ff_slot_q),
		.wdata({item_q.sequence_id, item_q.pic_order}),
		.raddr(scan_idx_q),
		.rdata(rd_data)
	);

	// address walk, one slot a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_run_q <= 1'b0;
			scan_idx_q <= '0;
			valid_s1   <= 1'b0;
			idx_s1     <= '0;
		end else begin
			if (cmd.scan_start) begin
				scan_run_q <= 1'b1;
				scan_idx_q <= '0;
			end else if (scan_run_q) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_idx_q == SLOT_LAST) begin
					scan_run_q <= 1'b0;
				end
			end
			valid_s1 <= scan_run_q;
			idx_s1   <= scan_idx_q;
		end
	end

	// unsigned key: sequence id, then order count with sign flipped
	always_comb begin
		s1_used  = used_q[idx_s1];
		s1_pend  = pend_q[idx_s1];
		key_rd   = {rd_data[ENTRY_W-1:ORDER_W], ~rd_data[ORDER_W-1], rd_data[ORDER_W-2:0]};
		key_best = {best_data_q[ENTRY_W-1:ORDER_W], ~best_data_q[ORDER_W-1],
			best_data_q[ORDER_W-2:0]};
		better   = !best_valid_q || (key_rd < key_best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_cnt_q   <= '0;
			pend_cnt_q   <= '0;
			best_valid_q <= 1'b0;
			best_slot_q  <= '0;
			ff_valid_q   <= 1'b0;
			ff_slot_q    <= '0;
		end else if (cmd.scan_start) begin
			used_cnt_q   <= '0;
			pend_cnt_q   <= '0;
			best_valid_q <= 1'b0;
			ff_valid_q   <= 1'b0;
		end else if (valid_s1) begin
			if (s1_used) begin
				used_cnt_q <= used_cnt_q + 1'b1;
			end
			if (s1_used && s1_pend) begin
				pend_cnt_q <= pend_cnt_q + 1'b1;
				if (better) begin
					best_valid_q <= 1'b1;
					best_slot_q  <= idx_s1;
				end
			end
			if (!s1_used && !ff_valid_q) begin
				ff_valid_q <= 1'b1;
				ff_slot_q  <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_used && s1_pend && better) begin
			best_data_q <= rd_data;
		end
	end

	// bump decision for this pass and for the one after it
	always_comb begin
		pend_ext = CMP_W'(pend_cnt_q);
		pend_dec = pend_ext - 1'b1;
		used_ext = CMP_W'(used_cnt_q);
		mr_ext   = CMP_W'(reorder_lim_q);
		mbs_ext  = CMP_W'(max_buffer_size_q);
		flush_op = (item_q.opcode == OP_FLUSH);
		bump_cond_now  = best_valid_q &&
			(flush_op || (pend_ext > mr_ext) || (used_ext >= mbs_ext));
		bump_cond_next = (pend_ext > CMP_W'(1)) &&
			(flush_op || (pend_dec > mr_ext) || (used_ext >= mbs_ext));
	end

	assign st.op         = item_q.opcode;
	assign st.scan_done  = valid_s1 && (idx_s1 == SLOT_LAST);
	assign st.free_found = ff_valid_q;
	assign st.go_now     = bump_cond_now;
	assign st.go_next    = bump_cond_next;

	// next result beat
	always_comb begin
		res_n = '0;
		res_n.last_result = cmd.res_last;
		case (cmd.res_kind)
			RES_FULL: begin
				res_n.status = 1'b1;
			end
			RES_INSERT: begin
				res_n.emitted         = 1'b1;
				res_n.result_slot     = SLOT_FIELD_W'(ff_slot_q);
				res_n.result_order    = item_q.pic_order;
				res_n.result_sequence = item_q.sequence_id;
			end
			RES_BUMP: begin
				res_n.emitted         = 1'b1;
				res_n.result_slot     = SLOT_FIELD_W'(best_slot_q);
				res_n.result_order    = best_data_q[ORDER_W-1:0];
				res_n.result_sequence = best_data_q[ENTRY_W-1:ORDER_W];
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= res_n;
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

// ===== rtl/pbob_ctrl.sv =====
// controller: sequences dispatch, slot scans and result beats
// depends on pbob_pkg
`default_nettype none

module pbob_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pbob_pkg::status_t st,
	output      logic              busy,
	output      pbob_pkg::cmd_t    cmd,
	output      logic              strobe
);

	import pbob_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DECIDE
	} state_t;

	state_t               state_q;
	logic [RES_CNT_W-1:0] n_q;
	logic                 strobe_q;
	logic                 bump_last;
	logic                 scan_op;

	assign bump_last = !st.go_next || (n_q == RES_CNT_W'(MAX_RESULTS - 1));
	assign scan_op   = (st.op == OP_INSERT) || (st.op == OP_DRAIN) || (st.op == OP_FLUSH);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.latch = start;
			end
			S_DISPATCH: begin
				case (st.op)
					OP_INSERT: begin
						cmd.sweep      = 1'b1;
						cmd.scan_start = 1'b1;
					end
					OP_DRAIN, OP_FLUSH: begin
						cmd.scan_start = 1'b1;
					end
					OP_MARK: begin
						cmd.mark     = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_last = 1'b1;
					end
					OP_EVICT: begin
						cmd.evict    = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_last = 1'b1;
					end
					OP_DROP: begin
						cmd.drop     = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_last = 1'b1;
					end
					default: begin
						cmd.res_load = 1'b1;
						cmd.res_last = 1'b1;
					end
				endcase
			end
			S_DECIDE: begin
				cmd.res_load = 1'b1;
				if (st.op == OP_INSERT) begin
					cmd.ins_write = st.free_found;
					cmd.res_kind  = st.free_found ? RES_INSERT : RES_FULL;
					cmd.res_last  = 1'b1;
				end else if (st.go_now) begin
					cmd.bump       = 1'b1;
					cmd.res_kind   = RES_BUMP;
					cmd.res_last   = bump_last;
					cmd.scan_start = !bump_last;
				end else begin
					cmd.res_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.res_load;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DISPATCH;
						n_q     <= '0;
					end
				end
				S_DISPATCH: begin
					state_q <= scan_op ? S_SCAN : S_IDLE;
				end
				S_SCAN: begin
					if (st.scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (cmd.scan_start) begin
						state_q <= S_SCAN;
						n_q     <= n_q + 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;

endmodule

`default_nettype wire

// ===== rtl/picture_buffer_output_bumping.sv =====
// top level of the picture buffer output bumping block
// depends on pbob_pkg, pbob_ctrl, pbob_dp and the assertion macro header
`default_nettype none
`include "picture_buffer_output_bumping_defines.svh"

// usage
// - command beat: taken at a rising edge with start high and busy low;
//   busy drops in the cycle that shows the last result beat of that command
// - result beats: one per cycle at most, each shown for exactly one cycle
//   with strobe high; last_result marks the final beat of a command.
//   the receiver cannot stall, so every beat must be taken as it comes
// - config: cfg_we writes cfg_data to register cfg_index
//   (0 reorder limit, 1 buffer size limit); only write while busy is low
// - sequence: mark, evict, drop and unknown opcodes give their beat
//   straight from dispatch; insert takes one slot scan; drain and flush
//   give their first beat after one slot scan, then one rescan per
//   further bumped picture, up to 16 pictures per command
// - the scan reads the entry ram one slot a cycle, which sets the rate
// - reset clears all slot flags, no current picture, reorder limit 0 and
//   max_buffer_size 16; the entry ram holds no reset value and its data is
//   only used for occupied slots
module picture_buffer_output_bumping #(
	parameter int unsigned BUFFER_SLOTS = pbob_pkg::BUFFER_SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// command channel
	input  wire logic                            start,
	output      logic                            busy,
	input  wire pbob_pkg::in_t                   item,
	// result channel
	output      logic                            strobe,
	output      pbob_pkg::out_t                  result,
	// config write port
	input  wire logic                            cfg_we,
	input  wire logic [pbob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pbob_pkg::CFG_DATA_W-1:0] cfg_data
);

	import pbob_pkg::*;

	cmd_t    cmd;
	status_t st;

	// controller: dispatch, scan passes, result beat timing
	pbob_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe)
	);

	// datapath: slot flags, entry ram, min search, result register
	pbob_dp #(
		.BUFFER_SLOTS(BUFFER_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.st       (st),
		.result   (result)
	);

	// a taken command keeps the block busy until its last beat
	`PBOB_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "command beat not held busy")
	`PBOB_ASSERT_SAME(a_last_frees, clk, arst_n, strobe && result.last_result, !busy, "busy after last beat")
	// only bumps come before the last beat of a command
	`PBOB_ASSERT_SAME(a_mid_bump, clk, arst_n, strobe && !result.last_result, busy && result.emitted, "bad mid beat")
	// a full buffer carries no picture
	`PBOB_ASSERT_SAME(a_full_empty, clk, arst_n, strobe && result.status, !result.emitted && (result.result_order == '0), "full beat carries a picture")

endmodule

`default_nettype wire
